FILE: src/tlbpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Shared types and fixed constants of the TLB / page table translator.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

  localparam int ADDR_W      = 16;
  localparam int CNT_W       = 16;
  localparam int RECIP_SHIFT = 32;
  localparam int PROD_W      = 48;

  localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SPLIT1,
    ST_SPLIT2,
    ST_SPLIT3,
    ST_LOOK,
    ST_MAP
  } state_e;

  typedef struct packed {
    logic lookup;
    logic push;
  } tlb_ctrl_t;

endpackage

FILE: src/tlbpt_addr_split.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbpt_addr_split
// Three-stage split of a logical address into page number and offset, using
// reciprocal multiplies so spans and page counts need not be powers of two.
// ----------------------------------------------------------------------------
module tlbpt_addr_split #(
  parameter int OFFSET_SPAN  = 256,
  parameter int PAGE_ENTRIES = 256
) (
  input  logic                                clk_i,
  input  logic [tlbpt_pkg::ADDR_W-1:0]        addr_i,
  output logic [$clog2(PAGE_ENTRIES)-1:0]     page_o,
  output logic [$clog2(OFFSET_SPAN)-1:0]      offset_o
);

  localparam int PW     = $clog2(PAGE_ENTRIES);
  localparam int OFF_W  = $clog2(OFFSET_SPAN);
  localparam int Q1_MAX = 65535 / OFFSET_SPAN;
  localparam int Q1W    = $clog2(Q1_MAX + 1);
  localparam int Q2_RAW = $clog2((Q1_MAX / PAGE_ENTRIES) + 1);
  localparam int Q2W    = (Q2_RAW < 1) ? 1 : Q2_RAW;
  localparam int PRW    = tlbpt_pkg::PROD_W;
  localparam int SH     = tlbpt_pkg::RECIP_SHIFT;

  // floor(2^32 / d) + 1 is exact for 16-bit dividends
  localparam logic [PRW-1:0] M1 = PRW'((64'd1 << SH) / OFFSET_SPAN + 1);
  localparam logic [PRW-1:0] M2 = PRW'((64'd1 << SH) / PAGE_ENTRIES + 1);

  logic [PRW-1:0]   prod1;
  logic [PRW-1:0]   prod2;
  logic [Q1W-1:0]   q1_q;
  logic [Q2W-1:0]   q2_q;
  logic [15:0]      q1_span;
  logic [31:0]      q2_pages;
  logic [OFF_W-1:0] off_q;
  logic [PW-1:0]    page_q;

  assign prod1    = PRW'(addr_i) * M1;
  assign prod2    = PRW'(q1_q) * M2;
  assign q1_span  = 16'(32'(q1_q) * 32'(OFFSET_SPAN));
  assign q2_pages = 32'(q2_q) * 32'(PAGE_ENTRIES);

  always_ff @(posedge clk_i) begin
    q1_q   <= prod1[SH +: Q1W];
    q2_q   <= prod2[SH +: Q2W];
    off_q  <= OFF_W'(addr_i - q1_span);
    page_q <= PW'(32'(q1_q) - q2_pages);
  end

  assign page_o   = page_q;
  assign offset_o = off_q;

endmodule

FILE: src/tlbpt_tlb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbpt_tlb
// Translation buffer: slot registers with parallel compare and push-front
// insertion that drops the oldest slot when full.
// ----------------------------------------------------------------------------
module tlbpt_tlb #(
  parameter int TLB_ENTRIES = 16,
  parameter int PW          = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tlbpt_pkg::tlb_ctrl_t ctrl_i,
  input  logic [PW-1:0]        page_i,
  input  logic [PW-1:0]        push_frame_i,
  output logic                 hit_o,
  output logic [PW-1:0]        frame_o
);

  localparam int FILL_W = $clog2(TLB_ENTRIES + 1);

  logic [PW-1:0]     slot_page_q  [TLB_ENTRIES];
  logic [PW-1:0]     slot_frame_q [TLB_ENTRIES];
  logic [FILL_W-1:0] fill_q;
  logic              match;
  logic [PW-1:0]     match_frame;
  logic              hit_q;
  logic [PW-1:0]     frame_q;

  // later slots override earlier ones
  always_comb begin
    match       = 1'b0;
    match_frame = '0;
    for (int k = 0; k < TLB_ENTRIES; k++) begin
      if ((FILL_W'(k) < fill_q) && (slot_page_q[k] == page_i)) begin
        match       = 1'b1;
        match_frame = slot_frame_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      hit_q  <= 1'b0;
    end else begin
      if (ctrl_i.lookup) begin
        hit_q <= match;
      end
      if (ctrl_i.push && (fill_q != FILL_W'(TLB_ENTRIES))) begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.lookup) begin
      frame_q <= match_frame;
    end
    if (ctrl_i.push) begin
      slot_page_q[0]  <= page_i;
      slot_frame_q[0] <= push_frame_i;
      for (int k = 1; k < TLB_ENTRIES; k++) begin
        slot_page_q[k]  <= slot_page_q[k-1];
        slot_frame_q[k] <= slot_frame_q[k-1];
      end
    end
  end

  assign hit_o   = hit_q;
  assign frame_o = frame_q;

endmodule

FILE: src/tlbpt_page_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbpt_page_map
// Page table memory, one {valid, frame} word per page, registered read,
// cleared by a sweep after reset.
// ----------------------------------------------------------------------------
module tlbpt_page_map #(
  parameter int PAGE_ENTRIES = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [$clog2(PAGE_ENTRIES)-1:0] raddr_i,
  input  logic                            we_i,
  input  logic [$clog2(PAGE_ENTRIES)-1:0] waddr_i,
  input  logic [$clog2(PAGE_ENTRIES)-1:0] wframe_i,
  output logic                            rvalid_o,
  output logic [$clog2(PAGE_ENTRIES)-1:0] rframe_o,
  output logic                            busy_o
);

  localparam int PW = $clog2(PAGE_ENTRIES);

  logic [PW:0]   mem [PAGE_ENTRIES];
  logic [PW:0]   rdata_q;
  logic [PW-1:0] clr_cnt_q;
  logic          busy_q;
  logic          mem_we;
  logic [PW-1:0] mem_waddr;
  logic [PW:0]   mem_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      clr_cnt_q <= '0;
    end else if (busy_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == PW'(PAGE_ENTRIES - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_comb begin
    if (busy_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = '0;
    end else begin
      mem_we    = we_i;
      mem_waddr = waddr_i;
      mem_wdata = {1'b1, wframe_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rvalid_o = rdata_q[PW];
  assign rframe_o = rdata_q[PW-1:0];
  assign busy_o   = busy_q;

endmodule

FILE: src/tlb_page_table_translator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_page_table_translator
// Logical to physical translation through a TLB backed by a page table,
// with demand allocation of frames and saturating hit / fault counts.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------
//  in      | input     | in_valid_i/in_stall_o   | logical_address_i
//  out     | output    | out_valid_o/out_stall_i | phys_addr_o, tlb_hit_o,
//          |           |                         | page_fault_o, hit_total_o,
//          |           |                         | fault_total_o
//
// One item at a time: accept, three address split stages, TLB compare
// with page table read, then the commit that writes back and loads the
// result register. The page table's registered read sets the final two steps.
// After reset the page table is swept clear, and in_stall_o stays high
// until the sweep is done. A stalled result holds in the output register;
// the commit waits only while that register is full and out_stall_i is high.
// ----------------------------------------------------------------------------
module tlb_page_table_translator #(
  parameter int TLB_ENTRIES  = 16,
  parameter int PAGE_ENTRIES = 256,
  parameter int OFFSET_SPAN  = 256
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [tlbpt_pkg::ADDR_W-1:0]       logical_address_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [tlbpt_pkg::ADDR_W-1:0]       phys_addr_o,
  output logic                               tlb_hit_o,
  output logic                               page_fault_o,
  output logic [tlbpt_pkg::CNT_W-1:0]        hit_total_o,
  output logic [tlbpt_pkg::CNT_W-1:0]        fault_total_o
);

  localparam int PW    = $clog2(PAGE_ENTRIES);
  localparam int OFF_W = $clog2(OFFSET_SPAN);
  localparam int CW    = tlbpt_pkg::CNT_W;
  localparam int AW    = tlbpt_pkg::ADDR_W;

  tlbpt_pkg::state_e    state_q, state_d;
  tlbpt_pkg::tlb_ctrl_t tlb_ctrl;

  logic [AW-1:0]    addr_q;
  logic [PW-1:0]    page;
  logic [OFF_W-1:0] offset;
  logic             tlb_hit;
  logic [PW-1:0]    tlb_frame;
  logic             pm_valid;
  logic [PW-1:0]    pm_frame;
  logic             pm_busy;
  logic             accept;
  logic             commit;
  logic             fault;
  logic [PW-1:0]    frame;
  logic [PW:0]      next_free_q;
  logic [CW-1:0]    hit_cnt_q;
  logic [CW-1:0]    fault_cnt_q;
  logic [CW-1:0]    hit_cnt_d;
  logic [CW-1:0]    fault_cnt_d;
  logic             out_valid_q;
  logic [AW-1:0]    phys_q;
  logic             hit_flag_q;
  logic             fault_flag_q;

  tlbpt_addr_split #(
    .OFFSET_SPAN  (OFFSET_SPAN),
    .PAGE_ENTRIES (PAGE_ENTRIES)
  ) u_split (
    .clk_i    (clk_i),
    .addr_i   (addr_q),
    .page_o   (page),
    .offset_o (offset)
  );

  tlbpt_tlb #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .PW          (PW)
  ) u_tlb (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (tlb_ctrl),
    .page_i       (page),
    .push_frame_i (PW'(next_free_q)),
    .hit_o        (tlb_hit),
    .frame_o      (tlb_frame)
  );

  tlbpt_page_map #(
    .PAGE_ENTRIES (PAGE_ENTRIES)
  ) u_page_map (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .raddr_i  (page),
    .we_i     (commit && fault),
    .waddr_i  (page),
    .wframe_i (PW'(next_free_q)),
    .rvalid_o (pm_valid),
    .rframe_o (pm_frame),
    .busy_o   (pm_busy)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tlbpt_pkg::ST_CLEAR:  if (!pm_busy) state_d = tlbpt_pkg::ST_IDLE;
      tlbpt_pkg::ST_IDLE:   if (in_valid_i) state_d = tlbpt_pkg::ST_SPLIT1;
      tlbpt_pkg::ST_SPLIT1: state_d = tlbpt_pkg::ST_SPLIT2;
      tlbpt_pkg::ST_SPLIT2: state_d = tlbpt_pkg::ST_SPLIT3;
      tlbpt_pkg::ST_SPLIT3: state_d = tlbpt_pkg::ST_LOOK;
      tlbpt_pkg::ST_LOOK:   state_d = tlbpt_pkg::ST_MAP;
      tlbpt_pkg::ST_MAP:    if (!out_valid_q || !out_stall_i) state_d = tlbpt_pkg::ST_IDLE;
      default:              state_d = tlbpt_pkg::ST_CLEAR;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall_o      = 1'b1;
    tlb_ctrl.lookup = 1'b0;
    commit          = 1'b0;
    unique case (state_q)
      tlbpt_pkg::ST_IDLE: in_stall_o      = 1'b0;
      tlbpt_pkg::ST_LOOK: tlb_ctrl.lookup = 1'b1;
      tlbpt_pkg::ST_MAP:  commit          = !out_valid_q || !out_stall_i;
      default: ;
    endcase
    tlb_ctrl.push = commit && fault;
  end

  assign accept = in_valid_i && !in_stall_o;
  assign fault  = !tlb_hit && !pm_valid;
  assign frame  = tlb_hit ? tlb_frame : (fault ? PW'(next_free_q) : pm_frame);

  assign hit_cnt_d   = (tlb_hit && (hit_cnt_q != tlbpt_pkg::CNT_MAX)) ?
                       hit_cnt_q + 1'b1 : hit_cnt_q;
  assign fault_cnt_d = (fault && (fault_cnt_q != tlbpt_pkg::CNT_MAX)) ?
                       fault_cnt_q + 1'b1 : fault_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tlbpt_pkg::ST_CLEAR;
      next_free_q <= '0;
      hit_cnt_q   <= '0;
      fault_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        hit_cnt_q   <= hit_cnt_d;
        fault_cnt_q <= fault_cnt_d;
        if (fault) begin
          next_free_q <= next_free_q + 1'b1;
        end
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q <= logical_address_i;
    end
    if (commit) begin
      phys_q       <= AW'(32'(frame) * 32'(OFFSET_SPAN) + 32'(offset));
      hit_flag_q   <= tlb_hit;
      fault_flag_q <= fault;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign phys_addr_o   = phys_q;
  assign tlb_hit_o     = hit_flag_q;
  assign page_fault_o  = fault_flag_q;
  assign hit_total_o   = hit_cnt_q;
  assign fault_total_o = fault_cnt_q;

  a_hit_xor_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(tlb_hit_o && page_fault_o))
    else $error("hit and fault flagged on one item");

  a_clear_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pm_busy |-> in_stall_o)
    else $error("input taken during page table sweep");

  a_frames_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_free_q <= (PW+1)'(PAGE_ENTRIES))
    else $error("more frames allocated than pages");

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_o)
    else $error("committed result not presented");

endmodule
